// ===== src/texture_descriptor_checker_defines.svh =====
// shared assertion macros for the descriptor checker
`ifndef TEXTURE_DESCRIPTOR_CHECKER_DEFINES_SVH
`define TEXTURE_DESCRIPTOR_CHECKER_DEFINES_SVH

// same-cycle implication, checked outside reset
`define TDC_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, checked outside reset
`define TDC_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== src/tdc_pkg.sv =====
`default_nettype none

package tdc_pkg;

   // default limits of the build
   localparam int unsigned DEF_MAX_EXTENT      = 16384;
   localparam int unsigned DEF_MAX_LAYER_COUNT = 2048;
   localparam int unsigned DEF_MIP_LIMIT       = 32;
   localparam int unsigned DEF_ALPHA_MAX       = 3;

   // register reset values
   localparam logic [14:0] RST_MAX_EXTENT  = 15'd16384;
   localparam logic [11:0] RST_MAX_DEPTH   = 12'd2048;
   localparam logic [11:0] RST_MAX_LAYERS  = 12'd2048;
   localparam logic [17:0] RST_MAX_SUBRES  = 18'h3FFFF;
   localparam logic [47:0] RST_MAX_BYTES   = 48'hFFFF_FFFF_FFFF;

   // register indexes
   localparam logic [2:0] CSR_MAX_EXTENT = 3'd0;
   localparam logic [2:0] CSR_MAX_DEPTH  = 3'd1;
   localparam logic [2:0] CSR_MAX_LAYERS = 3'd2;
   localparam logic [2:0] CSR_MAX_SUBRES = 3'd3;
   localparam logic [2:0] CSR_MAX_BYTES  = 3'd4;

   // status codes
   localparam logic [3:0] ST_OK          = 4'd0;
   localparam logic [3:0] ST_BAD_ENUM    = 4'd1;
   localparam logic [3:0] ST_BAD_EXTENT  = 4'd2;
   localparam logic [3:0] ST_MIPS        = 4'd3;
   localparam logic [3:0] ST_DEPTH       = 4'd4;
   localparam logic [3:0] ST_LAYERS      = 4'd5;
   localparam logic [3:0] ST_CUBE        = 4'd6;
   localparam logic [3:0] ST_SRGB        = 4'd7;
   localparam logic [3:0] ST_NORMAL      = 4'd8;
   localparam logic [3:0] ST_HDR         = 4'd9;
   localparam logic [3:0] ST_SUBRES      = 4'd10;
   localparam logic [3:0] ST_BUDGET      = 4'd11;

   // texture kinds and semantics
   localparam logic [2:0] KIND_2D         = 3'd0;
   localparam logic [2:0] KIND_2D_ARRAY   = 3'd1;
   localparam logic [2:0] KIND_CUBE       = 3'd2;
   localparam logic [2:0] KIND_CUBE_ARRAY = 3'd3;
   localparam logic [2:0] KIND_VOLUME     = 3'd4;
   localparam logic [2:0] SEM_COLOR       = 3'd0;
   localparam logic [2:0] SEM_NORMAL      = 3'd2;
   localparam logic [2:0] SEM_HDR         = 3'd3;
   localparam logic [4:0] FORMAT_COUNT    = 5'd27;

   typedef struct packed {
      logic       block4;    // 4x4 block compressed
      logic [2:0] bb_log2;   // log2 of bytes per block
      logic [2:0] channels;
      logic       hdr_ok;    // float storage or hdr-capable block format
      logic       srgb;
   } fmt_info_type;

   typedef struct packed {
      logic load_req;
      logic run_check;
      logic mul_first;
      logic mul_second;
      logic accumulate;
      logic load_rsp;
   } ctrl_cmd_type;

   typedef struct packed {
      logic chk_fail;
      logic last_mip;
   } dp_status_type;

   // per-format properties
   function automatic fmt_info_type fmt_lookup(input logic [4:0] code);
      fmt_info_type r;
      r = '0;
      unique case (code)
         5'd0:  r = '{1'b0, 3'd0, 3'd1, 1'b0, 1'b0};
         5'd1:  r = '{1'b0, 3'd1, 3'd2, 1'b0, 1'b0};
         5'd2:  r = '{1'b0, 3'd2, 3'd4, 1'b0, 1'b0};
         5'd3:  r = '{1'b0, 3'd2, 3'd4, 1'b0, 1'b1};
         5'd4:  r = '{1'b0, 3'd1, 3'd1, 1'b0, 1'b0};
         5'd5:  r = '{1'b0, 3'd2, 3'd2, 1'b0, 1'b0};
         5'd6:  r = '{1'b0, 3'd3, 3'd4, 1'b0, 1'b0};
         5'd7:  r = '{1'b0, 3'd1, 3'd1, 1'b1, 1'b0};
         5'd8:  r = '{1'b0, 3'd2, 3'd2, 1'b1, 1'b0};
         5'd9:  r = '{1'b0, 3'd3, 3'd4, 1'b1, 1'b0};
         5'd10: r = '{1'b0, 3'd2, 3'd1, 1'b1, 1'b0};
         5'd11: r = '{1'b0, 3'd3, 3'd2, 1'b1, 1'b0};
         5'd12: r = '{1'b0, 3'd4, 3'd4, 1'b1, 1'b0};
         5'd13: r = '{1'b1, 3'd3, 3'd4, 1'b0, 1'b0};
         5'd14: r = '{1'b1, 3'd3, 3'd4, 1'b0, 1'b1};
         5'd15: r = '{1'b1, 3'd4, 3'd4, 1'b0, 1'b0};
         5'd16: r = '{1'b1, 3'd4, 3'd4, 1'b0, 1'b1};
         5'd17: r = '{1'b1, 3'd4, 3'd4, 1'b0, 1'b0};
         5'd18: r = '{1'b1, 3'd4, 3'd4, 1'b0, 1'b1};
         5'd19: r = '{1'b1, 3'd3, 3'd1, 1'b0, 1'b0};
         5'd20: r = '{1'b1, 3'd3, 3'd1, 1'b0, 1'b0};
         5'd21: r = '{1'b1, 3'd4, 3'd2, 1'b0, 1'b0};
         5'd22: r = '{1'b1, 3'd4, 3'd2, 1'b0, 1'b0};
         5'd23: r = '{1'b1, 3'd4, 3'd3, 1'b1, 1'b0};
         5'd24: r = '{1'b1, 3'd4, 3'd3, 1'b1, 1'b0};
         5'd25: r = '{1'b1, 3'd4, 3'd4, 1'b0, 1'b0};
         5'd26: r = '{1'b1, 3'd4, 3'd4, 1'b0, 1'b1};
         default: r = '0;
      endcase
      return r;
   endfunction

   // position of the highest set bit plus one
   function automatic logic [3:0] bit_len(input logic [14:0] v);
      logic [3:0] n;
      n = 4'd0;
      for (int i = 0; i < 15; i++) begin
         if (v[i]) begin
            n = 4'(i + 1);
         end
      end
      return n;
   endfunction

endpackage

`default_nettype wire

// ===== src/tdc_req_if.sv =====
`default_nettype none

interface tdc_req_if;
   logic        valid;
   logic        ready;
   logic [2:0]  texture_kind;
   logic [4:0]  format_code;
   logic [2:0]  usage_semantic;
   logic [2:0]  alpha_mode;
   logic [14:0] width;
   logic [14:0] height;
   logic [11:0] depth;
   logic [11:0] layer_count;
   logic [4:0]  mip_count;

   modport source (output valid, texture_kind, format_code, usage_semantic, alpha_mode,
                   width, height, depth, layer_count, mip_count, input ready);
   modport sink (input valid, texture_kind, format_code, usage_semantic, alpha_mode,
                 width, height, depth, layer_count, mip_count, output ready);
endinterface

`default_nettype wire

// ===== src/tdc_rsp_if.sv =====
`default_nettype none

interface tdc_rsp_if;
   logic        valid;
   logic        ready;
   logic [3:0]  status;
   logic [17:0] subresource_count;
   logic [47:0] total_bytes;

   modport source (output valid, status, subresource_count, total_bytes, input ready);
   modport sink (input valid, status, subresource_count, total_bytes, output ready);
endinterface

`default_nettype wire

// ===== src/tdc_csr_if.sv =====
`default_nettype none

interface tdc_csr_if;
   logic        valid;
   logic        ready;
   logic [2:0]  index;
   logic [47:0] data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== src/tdc_ctrl.sv =====
`default_nettype none

module tdc_ctrl (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    req_valid,
   output logic                   req_ready,
   output logic                   rsp_valid,
   input  wire                    rsp_ready,
   input  tdc_pkg::dp_status_type dp_status,
   output tdc_pkg::ctrl_cmd_type  cmd
);
   import tdc_pkg::*;

   typedef enum logic [5:0] {
      S_IDLE   = 6'b000001,
      S_CHECK  = 6'b000010,
      S_MULA   = 6'b000100,
      S_MULB   = 6'b001000,
      S_ACC    = 6'b010000,
      S_FINISH = 6'b100000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   // output slot can take a result
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   // commands to the datapath
   always_comb begin
      cmd            = '0;
      cmd.load_req   = (state_ff == S_IDLE) && req_valid;
      cmd.run_check  = (state_ff == S_CHECK);
      cmd.mul_first  = (state_ff == S_MULA);
      cmd.mul_second = (state_ff == S_MULB);
      cmd.accumulate = (state_ff == S_ACC);
      cmd.load_rsp   = (state_ff == S_FINISH) && out_free;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) state_in = S_CHECK;
         end
         S_CHECK: begin
            state_in = dp_status.chk_fail ? S_FINISH : S_MULA;
         end
         S_MULA:  state_in = S_MULB;
         S_MULB:  state_in = S_ACC;
         S_ACC: begin
            state_in = dp_status.last_mip ? S_FINISH : S_MULA;
         end
         S_FINISH: begin
            if (out_free) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // result valid flag
   always_comb begin
      if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

`default_nettype wire

// ===== src/tdc_datapath.sv =====
`default_nettype none

module tdc_datapath #(
   parameter int unsigned MAX_EXTENT      = tdc_pkg::DEF_MAX_EXTENT,
   parameter int unsigned MAX_LAYER_COUNT = tdc_pkg::DEF_MAX_LAYER_COUNT,
   parameter int unsigned MIP_LIMIT       = tdc_pkg::DEF_MIP_LIMIT,
   parameter int unsigned ALPHA_MAX       = tdc_pkg::DEF_ALPHA_MAX
) (
   input  wire                    clock,
   input  wire                    reset,
   input  tdc_pkg::ctrl_cmd_type  cmd,
   output tdc_pkg::dp_status_type dp_status,
   input  wire                    csr_write,
   input  wire  [2:0]             csr_index,
   input  wire  [47:0]            csr_data,
   input  wire  [2:0]             texture_kind,
   input  wire  [4:0]             format_code,
   input  wire  [2:0]             usage_semantic,
   input  wire  [2:0]             alpha_mode,
   input  wire  [14:0]            width,
   input  wire  [14:0]            height,
   input  wire  [11:0]            depth,
   input  wire  [11:0]            layer_count,
   input  wire  [4:0]             mip_count,
   output logic [3:0]             status,
   output logic [17:0]            subresource_count,
   output logic [47:0]            total_bytes
);
   import tdc_pkg::*;

   logic [14:0] max_extent_ff;
   logic [11:0] max_depth_ff;
   logic [11:0] max_layers_ff;
   logic [17:0] max_subres_ff;
   logic [47:0] max_bytes_ff;

   logic [2:0]  kind_ff, sem_ff, alpha_ff;
   logic [4:0]  fmt_ff, mips_ff;
   logic [14:0] w_ff, h_ff;
   logic [11:0] d_ff, layers_ff;

   fmt_info_type fmt;
   logic         is_cube, is_volume;
   logic [14:0]  ext_max;
   logic [3:0]   chk_status;
   logic [14:0]  surf;
   logic [19:0]  count_full;
   logic [17:0]  count_sat;

   logic [3:0]   pre_status_ff;
   logic [17:0]  count_ff;

   logic [4:0]   mip_ff;
   logic [14:0]  lw, lw1, lh, lh1, bx, by;
   logic [11:0]  ld, ld1;
   logic [14:0]  factor;
   logic [28:0]  mul_a;
   logic [14:0]  mul_b;
   logic [43:0]  mul_p;
   logic [43:0]  prod_ff;
   logic [47:0]  acc_ff;

   logic [3:0]   fin_status;
   logic [3:0]   status_ff;
   logic [17:0]  subres_ff;
   logic [47:0]  total_ff;

   // limit registers
   always_ff @(posedge clock) begin
      if (reset) begin
         max_extent_ff <= RST_MAX_EXTENT;
         max_depth_ff  <= RST_MAX_DEPTH;
         max_layers_ff <= RST_MAX_LAYERS;
         max_subres_ff <= RST_MAX_SUBRES;
         max_bytes_ff  <= RST_MAX_BYTES;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_MAX_EXTENT: max_extent_ff <= csr_data[14:0];
            CSR_MAX_DEPTH:  max_depth_ff  <= csr_data[11:0];
            CSR_MAX_LAYERS: max_layers_ff <= csr_data[11:0];
            CSR_MAX_SUBRES: max_subres_ff <= csr_data[17:0];
            CSR_MAX_BYTES:  max_bytes_ff  <= csr_data;
            default: ;
         endcase
      end
   end

   // descriptor capture
   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         kind_ff   <= texture_kind;
         fmt_ff    <= format_code;
         sem_ff    <= usage_semantic;
         alpha_ff  <= alpha_mode;
         w_ff      <= width;
         h_ff      <= height;
         d_ff      <= depth;
         layers_ff <= layer_count;
         mips_ff   <= mip_count;
      end
   end

   assign fmt       = fmt_lookup(fmt_ff);
   assign is_cube   = (kind_ff == KIND_CUBE) || (kind_ff == KIND_CUBE_ARRAY);
   assign is_volume = (kind_ff == KIND_VOLUME);

   // largest of the three base extents
   always_comb begin
      ext_max = (w_ff > h_ff) ? w_ff : h_ff;
      if ({3'b0, d_ff} > ext_max) ext_max = {3'b0, d_ff};
   end

   // ordered descriptor checks, first failure wins
   always_comb begin
      priority if (kind_ff > KIND_VOLUME || sem_ff > SEM_HDR ||
                   alpha_ff > 3'(ALPHA_MAX) || fmt_ff >= FORMAT_COUNT) begin
         chk_status = ST_BAD_ENUM;
      end else if (w_ff == '0 || h_ff == '0 || d_ff == '0 || layers_ff == '0 ||
                   mips_ff == '0 || w_ff > max_extent_ff || h_ff > max_extent_ff ||
                   {2'b0, w_ff} > 17'(MAX_EXTENT) || {2'b0, h_ff} > 17'(MAX_EXTENT) ||
                   d_ff > max_depth_ff || layers_ff > max_layers_ff ||
                   {2'b0, layers_ff} > 14'(MAX_LAYER_COUNT)) begin
         chk_status = ST_BAD_EXTENT;
      end else if ({1'b0, mips_ff} > {2'b0, bit_len(ext_max)} ||
                   {1'b0, mips_ff} > 6'(MIP_LIMIT)) begin
         chk_status = ST_MIPS;
      end else if (!is_volume && d_ff != 12'd1) begin
         chk_status = ST_DEPTH;
      end else if (kind_ff != KIND_2D_ARRAY && kind_ff != KIND_CUBE_ARRAY &&
                   layers_ff != 12'd1) begin
         chk_status = ST_LAYERS;
      end else if (is_cube && w_ff != h_ff) begin
         chk_status = ST_CUBE;
      end else if (fmt.srgb && sem_ff != SEM_COLOR) begin
         chk_status = ST_SRGB;
      end else if (sem_ff == SEM_NORMAL && fmt.channels < 3'd2) begin
         chk_status = ST_NORMAL;
      end else if (sem_ff == SEM_HDR && !fmt.hdr_ok) begin
         chk_status = ST_HDR;
      end else if (count_full > {2'b0, max_subres_ff}) begin
         chk_status = ST_SUBRES;
      end else begin
         chk_status = ST_OK;
      end
   end

   // surface and subresource counts
   assign surf       = is_cube ? (({3'b0, layers_ff} << 2) + ({3'b0, layers_ff} << 1))
                               : {3'b0, layers_ff};
   assign count_full = 20'(surf) * 20'(mips_ff);
   assign count_sat  = (count_full[19:18] != 2'b00) ? 18'h3FFFF : count_full[17:0];

   always_ff @(posedge clock) begin
      if (cmd.run_check) begin
         pre_status_ff <= chk_status;
         count_ff      <= (chk_status == ST_OK || chk_status == ST_SUBRES) ? count_sat
                                                                          : 18'd0;
      end
   end

   // level extents in blocks
   assign lw  = w_ff >> mip_ff;
   assign lh  = h_ff >> mip_ff;
   assign ld  = d_ff >> mip_ff;
   assign lw1 = (lw == '0) ? 15'd1 : lw;
   assign lh1 = (lh == '0) ? 15'd1 : lh;
   assign ld1 = (ld == '0) ? 12'd1 : ld;
   assign bx  = fmt.block4 ? ((lw1 >> 2) + 15'(lw1[1:0] != 2'b00)) : lw1;
   assign by  = fmt.block4 ? ((lh1 >> 2) + 15'(lh1[1:0] != 2'b00)) : lh1;
   assign factor = is_volume ? {3'b0, ld1} : surf;

   // shared multiplier: blocks per level, then times depth or surfaces
   assign mul_a = cmd.mul_first ? {14'b0, bx} : prod_ff[28:0];
   assign mul_b = cmd.mul_first ? by : factor;
   assign mul_p = 44'(mul_a) * 44'(mul_b);

   always_ff @(posedge clock) begin
      if (cmd.mul_first || cmd.mul_second) begin
         prod_ff <= mul_p;
      end
   end

   // byte accumulation and mip stepping
   always_ff @(posedge clock) begin
      if (cmd.run_check) begin
         acc_ff <= '0;
         mip_ff <= '0;
      end else if (cmd.accumulate) begin
         acc_ff <= acc_ff + (48'(prod_ff) << fmt.bb_log2);
         mip_ff <= mip_ff + 5'd1;
      end
   end

   assign dp_status.chk_fail = (chk_status != ST_OK);
   assign dp_status.last_mip = (mip_ff == mips_ff - 5'd1);

   // final status and result register
   always_comb begin
      if (pre_status_ff != ST_OK) begin
         fin_status = pre_status_ff;
      end else if (acc_ff > max_bytes_ff) begin
         fin_status = ST_BUDGET;
      end else begin
         fin_status = ST_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         status_ff <= fin_status;
         subres_ff <= count_ff;
         total_ff  <= (fin_status == ST_OK || fin_status == ST_BUDGET) ? acc_ff : 48'd0;
      end
   end

   assign status            = status_ff;
   assign subresource_count = subres_ff;
   assign total_bytes       = total_ff;

endmodule

`default_nettype wire

// ===== src/texture_descriptor_checker.sv =====
// texture descriptor checker
// req_if carries one descriptor per request; rsp_if returns one result per request
// with the status code of the first failing check, the subresource count and the
// total payload bytes of the whole mip chain. csr_if writes the five limit
// registers by index (0 max extent .. 4 byte budget); it is always ready and
// writes to indexes above 4 are dropped.
// a descriptor that fails a check goes from the check state straight to the final
// load; a passing descriptor runs every mip level, each as two passes through one
// shared multiplier and one accumulate step.
// one request is worked on at a time: the next request is taken only after the
// result of the last one is loaded.
// the result sits in an output register; a new request is accepted and worked on
// while it waits, and only the final load waits for the receiver to take it.
// reset clears the controller, the result valid flag and restores the limit
// registers to their defaults.
`default_nettype none

`include "texture_descriptor_checker_defines.svh"

module texture_descriptor_checker #(
   parameter int unsigned MAX_EXTENT      = tdc_pkg::DEF_MAX_EXTENT,
   parameter int unsigned MAX_LAYER_COUNT = tdc_pkg::DEF_MAX_LAYER_COUNT,
   parameter int unsigned MIP_LIMIT       = tdc_pkg::DEF_MIP_LIMIT,
   parameter int unsigned ALPHA_MAX       = tdc_pkg::DEF_ALPHA_MAX
) (
   input wire         clock,
   input wire         reset,
   tdc_req_if.sink    req_if,
   tdc_rsp_if.source  rsp_if,
   tdc_csr_if.sink    csr_if
);
   import tdc_pkg::*;

   ctrl_cmd_type  cmd;
   dp_status_type dp_status;
   logic          req_ready;
   logic          rsp_valid;

   assign req_if.ready = req_ready;
   assign rsp_if.valid = rsp_valid;
   assign csr_if.ready = 1'b1;

   // sequencing
   tdc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_if.ready),
      .dp_status (dp_status),
      .cmd       (cmd)
   );

   // checks, counts and byte sum
   tdc_datapath #(
      .MAX_EXTENT      (MAX_EXTENT),
      .MAX_LAYER_COUNT (MAX_LAYER_COUNT),
      .MIP_LIMIT       (MIP_LIMIT),
      .ALPHA_MAX       (ALPHA_MAX)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .dp_status         (dp_status),
      .csr_write         (csr_if.valid),
      .csr_index         (csr_if.index),
      .csr_data          (csr_if.data),
      .texture_kind      (req_if.texture_kind),
      .format_code       (req_if.format_code),
      .usage_semantic    (req_if.usage_semantic),
      .alpha_mode        (req_if.alpha_mode),
      .width             (req_if.width),
      .height            (req_if.height),
      .depth             (req_if.depth),
      .layer_count       (req_if.layer_count),
      .mip_count         (req_if.mip_count),
      .status            (rsp_if.status),
      .subresource_count (rsp_if.subresource_count),
      .total_bytes       (rsp_if.total_bytes)
   );

   // early failures report no counts
   `TDC_ASSERT_NOW(a_count_zero, rsp_valid && rsp_if.status != ST_OK && rsp_if.status != ST_SUBRES && rsp_if.status != ST_BUDGET, rsp_if.subresource_count == 18'd0, "count on early failure")
   // bytes only on ok or budget failure
   `TDC_ASSERT_NOW(a_bytes_zero, rsp_valid && rsp_if.status != ST_OK && rsp_if.status != ST_BUDGET, rsp_if.total_bytes == 48'd0, "bytes on failure")
   // a waiting result is never overwritten
   `TDC_ASSERT_NOW(a_no_overwrite, cmd.load_rsp, !rsp_valid || rsp_if.ready, "result overwritten")
   // one request in flight
   `TDC_ASSERT_NEXT(a_single, req_if.valid && req_ready, !req_ready, "second request taken")

endmodule

`default_nettype wire

// ===== tb/texture_descriptor_checker_test.sv =====
`timescale 1ns / 100ps

module texture_descriptor_checker_test;
   import tdc_pkg::*;

   typedef struct packed {
      logic [2:0]  kind;
      logic [4:0]  fmt;
      logic [2:0]  sem;
      logic [2:0]  alpha;
      logic [14:0] w;
      logic [14:0] h;
      logic [11:0] d;
      logic [11:0] layers;
      logic [4:0]  mips;
   } descriptor_type;

   typedef struct packed {
      logic [3:0]  status;
      logic [17:0] subres;
      logic [47:0] bytes;
   } verdict_type;

   typedef struct {
      descriptor_type desc;
      bit             typed;
      verdict_type    want;
   } stim_row_type;

   // format properties: block edge, bytes per block, channels, float bits, srgb
   localparam int FMT_BLK[27]   = '{1,1,1,1,1,1,1,1,1,1,1,1,1,4,4,4,4,4,4,4,4,4,4,4,4,4,4};
   localparam int FMT_BYTES[27] = '{1,2,4,4,2,4,8,2,4,8,4,8,16,8,8,16,16,16,16,8,8,
                                    16,16,16,16,16,16};
   localparam int FMT_CHAN[27]  = '{1,2,4,4,1,2,4,1,2,4,1,2,4,4,4,4,4,4,4,1,1,2,2,3,3,4,4};
   localparam int FMT_FLT[27]   = '{0,0,0,0,0,0,0,16,16,16,32,32,32,0,0,0,0,0,0,0,0,
                                    0,0,0,0,0,0};
   localparam int FMT_SRGB[27]  = '{0,0,0,1,0,0,0,0,0,0,0,0,0,0,1,0,1,0,1,0,0,0,0,0,0,0,1};

   logic clock;
   logic reset;

   tdc_req_if req_bus ();
   tdc_rsp_if rsp_bus ();
   tdc_csr_if csr_bus ();

   texture_descriptor_checker dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_bus),
      .rsp_if (rsp_bus),
      .csr_if (csr_bus)
   );

   // limit copy
   logic [14:0] lim_extent;
   logic [11:0] lim_depth;
   logic [11:0] lim_layers;
   logic [17:0] lim_subres;
   logic [47:0] lim_bytes;

   verdict_type pending_verdicts[$];
   int          mismatches;
   bit          stall_free;

   function automatic int highest_bit(input longint unsigned v);
      int n;
      n = 0;
      while (v != 0) begin
         n++;
         v >>= 1;
      end
      return n;
   endfunction

   function automatic longint unsigned clamp1(input longint unsigned v);
      return (v == 0) ? 1 : v;
   endfunction

   // expected status, subresource count and payload bytes of one descriptor
   function automatic verdict_type check_descriptor(input descriptor_type t);
      verdict_type     r;
      longint unsigned w, h, d, ly, mp, m, surf, cnt, total, lw, lh, ld, blk;
      bit              cube;
      int              f;
      r = '0;
      w = t.w; h = t.h; d = t.d; ly = t.layers; mp = t.mips;
      cube = (t.kind == KIND_CUBE) || (t.kind == KIND_CUBE_ARRAY);
      f = t.fmt;
      if (t.kind > KIND_VOLUME || t.sem > SEM_HDR || t.alpha > DEF_ALPHA_MAX ||
          t.fmt >= FORMAT_COUNT) begin
         r.status = ST_BAD_ENUM;
         return r;
      end
      if (w == 0 || h == 0 || d == 0 || ly == 0 || mp == 0 || w > lim_extent ||
          h > lim_extent || w > DEF_MAX_EXTENT || h > DEF_MAX_EXTENT ||
          d > lim_depth || ly > lim_layers || ly > DEF_MAX_LAYER_COUNT) begin
         r.status = ST_BAD_EXTENT;
         return r;
      end
      m = (w > h) ? w : h;
      if (d > m) m = d;
      if (mp > highest_bit(m) || mp > DEF_MIP_LIMIT) begin
         r.status = ST_MIPS;
         return r;
      end
      if (t.kind != KIND_VOLUME && d != 1) begin
         r.status = ST_DEPTH;
         return r;
      end
      if (t.kind != KIND_2D_ARRAY && t.kind != KIND_CUBE_ARRAY && ly != 1) begin
         r.status = ST_LAYERS;
         return r;
      end
      if (cube && w != h) begin
         r.status = ST_CUBE;
         return r;
      end
      if (FMT_SRGB[f] != 0 && t.sem != SEM_COLOR) begin
         r.status = ST_SRGB;
         return r;
      end
      if (t.sem == SEM_NORMAL && FMT_CHAN[f] < 2) begin
         r.status = ST_NORMAL;
         return r;
      end
      if (t.sem == SEM_HDR && FMT_FLT[f] == 0 && f != 23 && f != 24) begin
         r.status = ST_HDR;
         return r;
      end
      surf = ly * (cube ? 6 : 1);
      cnt = surf * mp;
      r.subres = (cnt > 18'h3FFFF) ? 18'h3FFFF : cnt[17:0];
      if (cnt > lim_subres) begin
         r.status = ST_SUBRES;
         return r;
      end
      total = 0;
      for (int i = 0; i < mp; i++) begin
         lw = clamp1(w >> i);
         lh = clamp1(h >> i);
         ld = clamp1(d >> i);
         blk = ((lw + FMT_BLK[f] - 1) / FMT_BLK[f]) * FMT_BYTES[f] *
               ((lh + FMT_BLK[f] - 1) / FMT_BLK[f]) * ld;
         total += blk * surf;
      end
      r.bytes = (total > 48'hFFFF_FFFF_FFFF) ? 48'hFFFF_FFFF_FFFF : total[47:0];
      r.status = (total > lim_bytes) ? ST_BUDGET : ST_OK;
      return r;
   endfunction

   // clock
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // run limit
   initial begin
      #200ms;
      $display("CHECKS FAILED");
      $finish;
   end

   // receiver stall pattern: bursts of stalls, random stall-free stretches
   initial begin
      int phase_len;
      int mode;
      rsp_bus.ready = 1'b0;
      forever begin
         phase_len = $urandom_range(5, 200);
         mode = stall_free ? 0 : $urandom_range(0, 3);
         repeat (phase_len) begin
            @(negedge clock);
            case (mode)
               0: rsp_bus.ready <= 1'b1;
               1: rsp_bus.ready <= ($urandom_range(0, 3) != 0);
               2: rsp_bus.ready <= ($urandom_range(0, 3) == 0);
               default: rsp_bus.ready <= ($urandom_range(0, 40) == 0);
            endcase
         end
      end
   end

   // result checking
   always @(posedge clock) begin
      verdict_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_verdicts.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result status=%0d", rsp_bus.status);
         end else begin
            want = pending_verdicts.pop_front();
            if (rsp_bus.status !== want.status || rsp_bus.subresource_count !== want.subres ||
                rsp_bus.total_bytes !== want.bytes) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: expected %0d/%0d/%0d got %0d/%0d/%0d",
                           want.status, want.subres, want.bytes, rsp_bus.status,
                           rsp_bus.subresource_count, rsp_bus.total_bytes);
            end
         end
      end
   end

   task automatic write_limit(input logic [2:0] idx, input logic [47:0] value);
      @(negedge clock);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data  <= value;
      @(posedge clock);
      while (!csr_bus.ready) @(posedge clock);
      case (idx)
         CSR_MAX_EXTENT: lim_extent = value[14:0];
         CSR_MAX_DEPTH:  lim_depth  = value[11:0];
         CSR_MAX_LAYERS: lim_layers = value[11:0];
         CSR_MAX_SUBRES: lim_subres = value[17:0];
         CSR_MAX_BYTES:  lim_bytes  = value;
         default: ;
      endcase
      @(negedge clock);
      csr_bus.valid <= 1'b0;
   endtask

   // sends one request, valid stays high afterwards for back-to-back bursts
   task automatic send_request(input descriptor_type t, input bit typed,
                               input verdict_type want);
      @(negedge clock);
      req_bus.valid          <= 1'b1;
      req_bus.texture_kind   <= t.kind;
      req_bus.format_code    <= t.fmt;
      req_bus.usage_semantic <= t.sem;
      req_bus.alpha_mode     <= t.alpha;
      req_bus.width          <= t.w;
      req_bus.height         <= t.h;
      req_bus.depth          <= t.d;
      req_bus.layer_count    <= t.layers;
      req_bus.mip_count      <= t.mips;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      pending_verdicts.push_back(typed ? want : check_descriptor(t));
   endtask

   task automatic drop_valid(input int gap);
      @(negedge clock);
      req_bus.valid <= 1'b0;
      repeat (gap) @(negedge clock);
   endtask

   task automatic drain_results();
      while (pending_verdicts.size() != 0) @(posedge clock);
      repeat (120) @(posedge clock);
   endtask

   function automatic descriptor_type random_descriptor();
      descriptor_type  t;
      longint unsigned m;
      if ($urandom_range(0, 9) < 2) begin
         t = $urandom;
         t.w = $urandom;
         t.h = $urandom;
         t.d = $urandom;
         t.layers = $urandom;
         if ($urandom_range(0, 1)) begin
            t.kind = $urandom_range(0, 4);
            t.fmt = $urandom_range(0, 26);
            t.sem = $urandom_range(0, 3);
            t.alpha = $urandom_range(0, 3);
         end
         return t;
      end
      t.kind  = $urandom_range(0, 4);
      t.fmt   = $urandom_range(0, 26);
      t.sem   = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 3) : SEM_COLOR;
      t.alpha = $urandom_range(0, 3);
      t.w = ($urandom_range(0, 15) == 0) ? $urandom_range(1, 16384) : $urandom_range(1, 64);
      t.h = ($urandom_range(0, 15) == 0) ? $urandom_range(1, 16384) : $urandom_range(1, 64);
      t.d = 1;
      t.layers = 1;
      if (t.kind == KIND_VOLUME)
         t.d = ($urandom_range(0, 15) == 0) ? $urandom_range(1, 2048) : $urandom_range(1, 32);
      if (t.kind == KIND_CUBE || t.kind == KIND_CUBE_ARRAY)
         t.h = t.w;
      if (t.kind == KIND_2D_ARRAY || t.kind == KIND_CUBE_ARRAY)
         t.layers = ($urandom_range(0, 15) == 0) ? $urandom_range(1, 2048) :
                    $urandom_range(1, 8);
      m = (t.w > t.h) ? t.w : t.h;
      if (t.d > m) m = t.d;
      t.mips = $urandom_range(1, highest_bit(m));
      return t;
   endfunction

   function automatic descriptor_type mk(input logic [2:0] k, input logic [4:0] f,
                                         input logic [2:0] s, input logic [2:0] a,
                                         input int w, input int h, input int d,
                                         input int l, input int m);
      descriptor_type t;
      t = '{k, f, s, a, w[14:0], h[14:0], d[11:0], l[11:0], m[4:0]};
      return t;
   endfunction

   initial begin
      stim_row_type   rows[$];
      descriptor_type t;
      verdict_type    none;
      int             burst;
      int             sent;
      none = '0;
      stall_free = 1'b0;
      mismatches = 0;
      reset = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.texture_kind = '0;
      req_bus.format_code = '0;
      req_bus.usage_semantic = '0;
      req_bus.alpha_mode = '0;
      req_bus.width = '0;
      req_bus.height = '0;
      req_bus.depth = '0;
      req_bus.layer_count = '0;
      req_bus.mip_count = '0;
      csr_bus.valid = 1'b0;
      csr_bus.index = '0;
      csr_bus.data = '0;
      lim_extent = RST_MAX_EXTENT;
      lim_depth  = RST_MAX_DEPTH;
      lim_layers = RST_MAX_LAYERS;
      lim_subres = RST_MAX_SUBRES;
      lim_bytes  = RST_MAX_BYTES;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed table: error codes and extremes
      rows.push_back('{mk(5, 0, 0, 0, 1, 1, 1, 1, 1), 1, '{ST_BAD_ENUM, 18'd0, 48'd0}});
      rows.push_back('{mk(7, 31, 7, 7, 32767, 32767, 4095, 4095, 31), 1,
                       '{ST_BAD_ENUM, 18'd0, 48'd0}});
      rows.push_back('{mk(0, 27, 0, 0, 1, 1, 1, 1, 1), 1, '{ST_BAD_ENUM, 18'd0, 48'd0}});
      rows.push_back('{mk(0, 0, 4, 0, 1, 1, 1, 1, 1), 1, '{ST_BAD_ENUM, 18'd0, 48'd0}});
      rows.push_back('{mk(0, 0, 0, 4, 1, 1, 1, 1, 1), 1, '{ST_BAD_ENUM, 18'd0, 48'd0}});
      rows.push_back('{mk(0, 0, 0, 0, 0, 1, 1, 1, 1), 1, '{ST_BAD_EXTENT, 18'd0, 48'd0}});
      rows.push_back('{mk(0, 0, 0, 0, 16385, 1, 1, 1, 1), 1,
                       '{ST_BAD_EXTENT, 18'd0, 48'd0}});
      rows.push_back('{mk(1, 0, 0, 0, 1, 1, 1, 2049, 1), 1, '{ST_BAD_EXTENT, 18'd0, 48'd0}});
      rows.push_back('{mk(0, 0, 0, 0, 1, 1, 1, 1, 0), 1, '{ST_BAD_EXTENT, 18'd0, 48'd0}});
      rows.push_back('{mk(0, 0, 0, 0, 4, 4, 1, 1, 4), 1, '{ST_MIPS, 18'd0, 48'd0}});
      rows.push_back('{mk(0, 0, 0, 0, 4, 4, 2, 1, 1), 1, '{ST_DEPTH, 18'd0, 48'd0}});
      rows.push_back('{mk(0, 0, 0, 0, 4, 4, 1, 2, 1), 1, '{ST_LAYERS, 18'd0, 48'd0}});
      rows.push_back('{mk(2, 0, 0, 0, 4, 8, 1, 1, 1), 1, '{ST_CUBE, 18'd0, 48'd0}});
      rows.push_back('{mk(0, 3, 1, 0, 4, 4, 1, 1, 1), 1, '{ST_SRGB, 18'd0, 48'd0}});
      rows.push_back('{mk(0, 0, 2, 0, 4, 4, 1, 1, 1), 1, '{ST_NORMAL, 18'd0, 48'd0}});
      rows.push_back('{mk(0, 0, 3, 0, 4, 4, 1, 1, 1), 1, '{ST_HDR, 18'd0, 48'd0}});
      rows.push_back('{mk(0, 0, 0, 0, 1, 1, 1, 1, 1), 1, '{ST_OK, 18'd1, 48'd1}});
      rows.push_back('{mk(0, 23, 3, 3, 5, 3, 1, 1, 3), 0, none});
      rows.push_back('{mk(0, 12, 0, 0, 16384, 16384, 1, 1, 15), 0, none});
      rows.push_back('{mk(3, 26, 0, 0, 16384, 16384, 1, 2048, 15), 0, none});
      rows.push_back('{mk(4, 9, 3, 2, 16384, 1, 2048, 1, 15), 0, none});
      rows.push_back('{mk(1, 21, 2, 1, 13, 7, 1, 3, 4), 0, none});
      foreach (rows[i]) begin
         send_request(rows[i].desc, rows[i].typed, rows[i].want);
         if ($urandom_range(0, 2) == 0) drop_valid($urandom_range(0, 5));
      end
      drop_valid(0);
      drain_results();

      // limit phases: zeros, maxima, random small, defaults, and ignored indexes
      for (int phase = 0; phase < 6; phase++) begin
         case (phase)
            0: begin
               write_limit(CSR_MAX_EXTENT, 48'd0);
               write_limit(CSR_MAX_DEPTH, 48'd0);
               write_limit(CSR_MAX_LAYERS, 48'd0);
               write_limit(CSR_MAX_SUBRES, 48'd0);
               write_limit(CSR_MAX_BYTES, 48'd0);
            end
            1: begin
               write_limit(CSR_MAX_EXTENT, 48'hFFFF_FFFF_FFFF);
               write_limit(CSR_MAX_DEPTH, 48'hFFFF_FFFF_FFFF);
               write_limit(CSR_MAX_LAYERS, 48'hFFFF_FFFF_FFFF);
               write_limit(CSR_MAX_SUBRES, 48'hFFFF_FFFF_FFFF);
               write_limit(CSR_MAX_BYTES, 48'hFFFF_FFFF_FFFF);
               write_limit(3'd7, 48'd0);
            end
            5: begin
               write_limit(CSR_MAX_EXTENT, 48'd16384);
               write_limit(CSR_MAX_DEPTH, 48'd2048);
               write_limit(CSR_MAX_LAYERS, 48'd2048);
               write_limit(CSR_MAX_SUBRES, 48'd262143);
               write_limit(CSR_MAX_BYTES, 48'hFFFF_FFFF_FFFF);
            end
            default: begin
               write_limit(CSR_MAX_EXTENT, $urandom_range(1, 64));
               write_limit(CSR_MAX_DEPTH, $urandom_range(1, 32));
               write_limit(CSR_MAX_LAYERS, $urandom_range(1, 8));
               write_limit(CSR_MAX_SUBRES, $urandom_range(1, 60));
               write_limit(CSR_MAX_BYTES, {$urandom, $urandom} & 48'h0000_0000_3FFF);
               write_limit($urandom_range(5, 6), {$urandom, $urandom});
            end
         endcase
         stall_free = (phase == 3);
         sent = 0;
         while (sent < 300) begin
            burst = $urandom_range(1, 20);
            repeat (burst) begin
               t = random_descriptor();
               send_request(t, 1'b0, none);
               sent++;
            end
            if (sent > 150 && sent <= 150 + burst) begin
               drop_valid(0);
               while (pending_verdicts.size() != 0) @(posedge clock);
            end else begin
               drop_valid(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30));
            end
         end
         drain_results();
      end

      if (mismatches == 0 && pending_verdicts.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
